### src/ekfbp_pkg.sv
// Shared types, constants and helper functions for the bicycle-model EKF predict core.
// Used by ekf_bicycle_predict_core; depends on nothing else.
package ekfbp_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int CNT_W = $clog2(CORDIC_STEPS);

	// Angle constants in Q4.28, CORDIC gain in Q2.30.
	localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
	localparam logic signed [33:0] ANG_HALF_PI = 34'sd421657428;
	localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629713;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [31:0] ATAN_Q30 [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	// Register indexes of the configuration channel.
	localparam logic [2:0] REG_INV_WB    = 3'd0;
	localparam logic [2:0] REG_Q_NORMAL  = 3'd1;
	localparam logic [2:0] REG_Q_MISSING = 3'd2;
	localparam logic [2:0] REG_INIT_X    = 3'd3;
	localparam logic [2:0] REG_INIT_Y    = 3'd4;
	localparam logic [2:0] REG_INIT_TH   = 3'd5;
	localparam logic [2:0] REG_INIT_VAR  = 3'd6;

	localparam logic [23:0] INV_WB_RST    = 24'd422813;
	localparam logic [31:0] Q_NORMAL_RST  = 32'd983040;
	localparam logic [31:0] Q_MISSING_RST = 32'd98304000;
	localparam logic [31:0] INIT_VAR_RST  = 32'd655360;

	localparam int IN_W  = 160;
	localparam int OUT_W = 384;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CSET  = 5'b00010,
		S_CITER = 5'b00100,
		S_MUL   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	// Micro-operations of the multiply sequence, one product each.
	typedef enum logic [3:0] {
		OP_A, OP_T, OP_DX, OP_DY, OP_DH, OP_G0, OP_G1,
		OP_P00A, OP_P00B, OP_P01A, OP_P01B, OP_P11A, OP_P11B
	} op_t;

	typedef enum logic [1:0] {
		PH_LO, PH_HI, PH_FIN, PH_RET
	} phase_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] val;
	} s32_t;

	typedef struct packed {
		logic               hit;
		logic signed [47:0] val;
	} s48_t;

	function automatic s32_t sat32(input logic signed [56:0] v);
		s32_t r;
		r.hit = 1'b0;
		r.val = v[31:0];
		if (v > 57'sd2147483647) begin
			r.hit = 1'b1;
			r.val = 32'sh7FFFFFFF;
		end else if (v < -57'sd2147483648) begin
			r.hit = 1'b1;
			r.val = 32'sh80000000;
		end
		return r;
	endfunction

	function automatic s48_t sat48(input logic signed [51:0] v);
		s48_t r;
		r.hit = 1'b0;
		r.val = v[47:0];
		if (v > 52'sh7FFFFFFFFFFF) begin
			r.hit = 1'b1;
			r.val = 48'sh7FFFFFFFFFFF;
		end else if (v < -52'sh800000000000) begin
			r.hit = 1'b1;
			r.val = 48'sh800000000000;
		end
		return r;
	endfunction

endpackage

### src/ekf_bicycle_predict_core.sv
// Predict step of an extended Kalman filter for a kinematic bicycle model.
// One shared CORDIC stage and one shared 35x24 multiplier under a sequencer.
// Depends on ekfbp_pkg.
//
// Usage:
//  Input beats arrive on s_axis_*. s_axis_tuser is req_type: 0 runs a predict
//  step with the distance, steering angle and measurement in s_axis_tdata,
//  1 copies the initial pose and variance from the configuration registers.
//  Every input beat yields exactly one output beat on m_axis_*, carrying the
//  new pose and covariance in m_axis_tdata and the saturation flag in tuser.
//  A predict beat runs a setup step and CORDIC_STEPS rotations for each of the
//  two angles, then thirteen products on the shared multiplier, each in the
//  phases low half, high half, rounding and accumulate, then hands over the
//  result and returns to idle. A load beat goes straight to the hand-over.
//  The block holds s_axis_tready low while one beat is in work and accepts
//  the next beat once it is back in idle, even while the previous result
//  still waits in the output register.
//  If the receiver stalls, a finished step waits until the output register
//  frees up. Configuration writes on cfg_* are always accepted and should be
//  issued only while the block is idle.
//  Reset puts the registers at their defaults, the pose at zero and the
//  covariance diagonal at 10.0, and clears all valid flags.
module ekf_bicycle_predict_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// travel_dist, steer_angle, meas_x, meas_y, meas_theta
	input  logic [ekfbp_pkg::IN_W-1:0] s_axis_tdata,
	// req_type
	input  logic                      s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// est_x, est_y, est_theta, cov_xx, cov_xy, cov_xt, cov_yy, cov_yt, cov_tt
	output logic [ekfbp_pkg::OUT_W-1:0] m_axis_tdata,
	// sat_flag
	output logic                      m_axis_tuser,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [31:0]               cfg_data
);
	import ekfbp_pkg::*;

	state_t state_q;
	op_t    op_q;
	phase_t ph_q;
	logic [CNT_W-1:0] cnt_q;
	logic csel_q, flip_q, sat_q, miss_q;

	logic [23:0] inv_q;
	logic [31:0] qn_q, qm_q, ivar_q;
	logic signed [31:0] ix_q, iy_q, ith_q;

	logic signed [31:0] pos_x_q, pos_y_q, head_q;
	logic signed [47:0] pxx_q, pxy_q, pxh_q, pyy_q, pyh_q, phh_q;

	logic signed [31:0] d_q, st_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] sd_q, cd_q, sh_q, ch_q;
	logic signed [33:0] a_q, t_q, dx_q, dy_q;
	logic signed [47:0] g0_q, g1_q;
	logic signed [51:0] acc_q;
	logic [58:0] pp_lo_q, pp_hi_q;
	logic signed [55:0] m_q;

	logic m_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic out_sat_q;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_sat_q;

	logic s_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// Angle reduction and fold into [-pi/2, pi/2] for the CORDIC setup.
	logic signed [33:0] ang, z1, z2, z3;
	logic flip_n;
	always_comb begin
		ang = csel_q ? {{2{head_q[31]}}, head_q} : {{2{st_q[31]}}, st_q};
		z1 = (ang > ANG_PI) ? ang - ANG_TWO_PI : ang;
		z2 = (z1 < -ANG_PI) ? z1 + ANG_TWO_PI : z1;
		flip_n = 1'b0;
		z3 = z2;
		if (z2 > ANG_HALF_PI) begin
			z3 = z2 - ANG_PI;
			flip_n = 1'b1;
		end else if (z2 < -ANG_HALF_PI) begin
			z3 = z2 + ANG_PI;
			flip_n = 1'b1;
		end
	end

	// One CORDIC rotation per cycle.
	logic [4:0] sft;
	logic signed [33:0] xs, ys, at, xn, yn, zn, sin_v, cos_v;
	always_comb begin
		sft = 5'(cnt_q);
		xs = x_q >>> sft;
		ys = y_q >>> sft;
		at = {2'b00, ATAN_Q30[sft]};
		if (!z_q[33]) begin
			xn = x_q - ys;
			yn = y_q + xs;
			zn = z_q - at;
		end else begin
			xn = x_q + ys;
			yn = y_q - xs;
			zn = z_q + at;
		end
		sin_v = flip_q ? -yn : yn;
		cos_v = flip_q ? -xn : xn;
	end

	// Operand selection for the shared multiplier.
	logic signed [34:0] op_a, u_w, v_w;
	logic signed [47:0] op_b;
	logic [34:0] amag;
	logic [47:0] bmag;
	logic neg;
	always_comb begin
		u_w = -{dy_q[33], dy_q};
		v_w = {dx_q[33], dx_q};
		op_a = u_w;
		op_b = phh_q;
		case (op_q)
			OP_A: begin
				op_a = {cd_q[33], cd_q};
				op_b = {{16{d_q[31]}}, d_q};
			end
			OP_T: begin
				op_a = {sd_q[33], sd_q};
				op_b = {{16{d_q[31]}}, d_q};
			end
			OP_DX: begin
				op_a = {ch_q[33], ch_q};
				op_b = {{14{a_q[33]}}, a_q};
			end
			OP_DY: begin
				op_a = {sh_q[33], sh_q};
				op_b = {{14{a_q[33]}}, a_q};
			end
			OP_DH: begin
				op_a = {t_q[33], t_q};
				op_b = {24'd0, inv_q};
			end
			OP_G0: begin
				op_a = u_w;
				op_b = phh_q;
			end
			OP_G1: begin
				op_a = v_w;
				op_b = phh_q;
			end
			OP_P00A: begin
				op_a = u_w;
				op_b = pxh_q;
			end
			OP_P00B: begin
				op_a = u_w;
				op_b = g0_q;
			end
			OP_P01A: begin
				op_a = u_w;
				op_b = pyh_q;
			end
			OP_P01B: begin
				op_a = v_w;
				op_b = g0_q;
			end
			OP_P11A: begin
				op_a = v_w;
				op_b = pyh_q;
			end
			OP_P11B: begin
				op_a = v_w;
				op_b = g1_q;
			end
			default: begin
				op_a = u_w;
				op_b = phh_q;
			end
		endcase
		neg  = op_a[34] ^ op_b[47];
		amag = op_a[34] ? 35'(-op_a) : 35'(op_a);
		bmag = op_b[47] ? 48'(-op_b) : 48'(op_b);
	end

	// Combine the partial products, round to the format of the operation and saturate the covariance products.
	logic [82:0] mag, rq, lim;
	logic signed [83:0] sv, r30, r4;
	logic signed [55:0] m_n;
	logic m_hit;
	always_comb begin
		mag = {24'd0, pp_lo_q} + {pp_hi_q, 24'd0};
		sv  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		r30 = (sv + 84'sd536870912) >>> 30;
		r4  = (sv + 84'sd8) >>> 4;
		rq  = (mag + 83'h8000) >> 16;
		lim = neg ? 83'h800000000000 : 83'h7FFFFFFFFFFF;
		m_hit = 1'b0;
		if (op_q == OP_A || op_q == OP_T || op_q == OP_DX || op_q == OP_DY) begin
			m_n = r30[55:0];
		end else if (op_q == OP_DH) begin
			m_n = r4[55:0];
		end else begin
			if (rq > lim) begin
				rq = lim;
				m_hit = 1'b1;
			end
			m_n = neg ? -$signed(rq[55:0]) : $signed(rq[55:0]);
		end
	end

	logic signed [31:0] qv;
	logic signed [51:0] m52;
	s32_t px_s, py_s, ph_s;
	s48_t g_s, acc_s, phh_s;
	always_comb begin
		qv  = miss_q ? qm_q : qn_q;
		m52 = m_q[51:0];
		px_s = sat32({{25{pos_x_q[31]}}, pos_x_q} + {m_q[55], m_q});
		py_s = sat32({{25{pos_y_q[31]}}, pos_y_q} + {m_q[55], m_q});
		ph_s = sat32({{25{head_q[31]}}, head_q} + {m_q[55], m_q});
		g_s  = sat48({{4{(op_q == OP_G0) ? pxh_q[47] : pyh_q[47]}},
			(op_q == OP_G0) ? pxh_q : pyh_q} + m52);
		acc_s = sat48(acc_q + m52);
		phh_s = sat48({{4{phh_q[47]}}, phh_q} + {20'd0, qv});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q  <= INV_WB_RST;
			qn_q   <= Q_NORMAL_RST;
			qm_q   <= Q_MISSING_RST;
			ix_q   <= '0;
			iy_q   <= '0;
			ith_q  <= '0;
			ivar_q <= INIT_VAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_INV_WB:    inv_q  <= cfg_data[23:0];
				REG_Q_NORMAL:  qn_q   <= cfg_data;
				REG_Q_MISSING: qm_q   <= cfg_data;
				REG_INIT_X:    ix_q   <= cfg_data;
				REG_INIT_Y:    iy_q   <= cfg_data;
				REG_INIT_TH:   ith_q  <= cfg_data;
				REG_INIT_VAR:  ivar_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_A;
			ph_q      <= PH_LO;
			cnt_q     <= '0;
			csel_q    <= 1'b0;
			flip_q    <= 1'b0;
			sat_q     <= 1'b0;
			miss_q    <= 1'b0;
			m_valid_q <= 1'b0;
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			head_q    <= '0;
			pxx_q     <= 48'sd655360;
			pxy_q     <= '0;
			pxh_q     <= '0;
			pyy_q     <= 48'sd655360;
			pyh_q     <= '0;
			phh_q     <= 48'sd655360;
		end else begin
			// A finished step fills the output register when empty or as the old beat leaves.
			if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						sat_q <= 1'b0;
						if (s_axis_tuser) begin
							pos_x_q <= ix_q;
							pos_y_q <= iy_q;
							head_q  <= ith_q;
							pxx_q   <= {16'd0, ivar_q};
							pyy_q   <= {16'd0, ivar_q};
							phh_q   <= {16'd0, ivar_q};
							pxy_q   <= '0;
							pxh_q   <= '0;
							pyh_q   <= '0;
							state_q <= S_DONE;
						end else begin
							miss_q  <= (s_axis_tdata[159:64] == '0);
							csel_q  <= 1'b0;
							state_q <= S_CSET;
						end
					end
				end
				S_CSET: begin
					cnt_q   <= '0;
					flip_q  <= flip_n;
					state_q <= S_CITER;
				end
				S_CITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
						if (csel_q) begin
							op_q    <= OP_A;
							ph_q    <= PH_LO;
							state_q <= S_MUL;
						end else begin
							csel_q  <= 1'b1;
							state_q <= S_CSET;
						end
					end
				end
				S_MUL: begin
					case (ph_q)
						PH_LO:  ph_q <= PH_HI;
						PH_HI:  ph_q <= PH_FIN;
						PH_FIN: begin
							sat_q <= sat_q | m_hit;
							ph_q  <= PH_RET;
						end
						PH_RET: begin
							ph_q <= PH_LO;
							op_q <= op_t'(op_q + 1'b1);
							case (op_q)
								OP_DX: begin
									pos_x_q <= px_s.val;
									sat_q   <= sat_q | px_s.hit;
								end
								OP_DY: begin
									pos_y_q <= py_s.val;
									sat_q   <= sat_q | py_s.hit;
								end
								OP_DH: begin
									head_q <= ph_s.val;
									sat_q  <= sat_q | ph_s.hit;
								end
								OP_G0, OP_G1: sat_q <= sat_q | g_s.hit;
								OP_P00B: begin
									pxx_q <= acc_s.val;
									sat_q <= sat_q | acc_s.hit;
								end
								OP_P01B: begin
									pxy_q <= acc_s.val;
									sat_q <= sat_q | acc_s.hit;
								end
								OP_P11B: begin
									pyy_q   <= acc_s.val;
									pxh_q   <= g0_q;
									pyh_q   <= g1_q;
									phh_q   <= phh_s.val;
									sat_q   <= sat_q | acc_s.hit | phh_s.hit;
									state_q <= S_DONE;
								end
								default: ;
							endcase
						end
						default: ph_q <= PH_LO;
					endcase
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			d_q  <= s_axis_tdata[31:0];
			st_q <= s_axis_tdata[63:32];
		end
		if (state_q == S_CSET) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= z3 <<< 2;
		end
		if (state_q == S_CITER) begin
			x_q <= xn;
			y_q <= yn;
			z_q <= zn;
			if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
				if (csel_q) begin
					sh_q <= sin_v;
					ch_q <= cos_v;
				end else begin
					sd_q <= sin_v;
					cd_q <= cos_v;
				end
			end
		end
		if (state_q == S_MUL) begin
			case (ph_q)
				PH_LO:  pp_lo_q <= amag * bmag[23:0];
				PH_HI:  pp_hi_q <= amag * bmag[47:24];
				PH_FIN: m_q <= m_n;
				PH_RET: begin
					case (op_q)
						OP_A:    a_q  <= m_q[33:0];
						OP_T:    t_q  <= m_q[33:0];
						OP_DX:   dx_q <= m_q[33:0];
						OP_DY:   dy_q <= m_q[33:0];
						OP_G0:   g0_q <= g_s.val;
						OP_G1:   g1_q <= g_s.val;
						OP_P00A: acc_q <= {{4{pxx_q[47]}}, pxx_q} + m52 + {20'd0, qv};
						OP_P01A: acc_q <= {{4{pxy_q[47]}}, pxy_q} + m52;
						OP_P11A: acc_q <= {{4{pyy_q[47]}}, pyy_q} + m52 + {20'd0, qv};
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
			out_data_q <= {phh_q, pyh_q, pyy_q, pxh_q, pxy_q, pxx_q, head_q, pos_y_q, pos_x_q};
			out_sat_q  <= sat_q;
		end
	end

`ifndef ASSERT_OFF
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_axis_tuser) |=> (state_q == S_DONE))
		else $error("load beat did not go straight to completion");
	a_load_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_axis_tuser) |=> !sat_q)
		else $error("load beat left the saturation flag set");
	a_mul_after_heading: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> csel_q)
		else $error("multiply sequence started before heading sin/cos");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CITER) |-> (32'(cnt_q) < CORDIC_STEPS))
		else $error("CORDIC counter out of range");
	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !m_valid_q) |=> m_valid_q)
		else $error("finished step did not raise output valid");
`endif

endmodule
